### rtl/audio_level_threshold_detector_assert.svh
// Assertion macros used by the checker.
`ifndef AUDIO_LEVEL_THRESHOLD_DETECTOR_ASSERT_SVH
`define AUDIO_LEVEL_THRESHOLD_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ALTD_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ALTD_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// Next-cycle implication, checked through reset as well.
`define ALTD_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

### rtl/altd_pkg.sv
package altd_pkg;

  localparam int MAX_FRAME_PAIRS_DEFAULT = 256;
  localparam int SAMPLE_WIDTH_DEFAULT    = 16;

  localparam int LEVEL_W    = 20;
  localparam int ALPHA_W    = 16;
  localparam int SUM_W      = 40;
  localparam int ALIGNED_W  = 16;
  localparam int SQ_W       = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 2'd1;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 20'd32768;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 16'd4588;

  typedef enum logic [1:0] {
    CHANGE_NONE  = 2'd0,
    CHANGE_ABOVE = 2'd1,
    CHANGE_BELOW = 2'd2
  } change_t;

  typedef struct packed {
    logic busy;
    logic done;
  } isqrt_status_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_avg;
    logic               above;
    change_t            change;
  } smooth_result_t;

endpackage

### rtl/altd_lane.sv
module altd_lane #(
  parameter int SAMPLE_WIDTH = altd_pkg::SAMPLE_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic [altd_pkg::SQ_W-1:0]      square
);
  import altd_pkg::*;

  localparam int ALIGN_UP   = (SAMPLE_WIDTH < ALIGNED_W) ? (ALIGNED_W - SAMPLE_WIDTH) : 0;
  localparam int ALIGN_DOWN = (SAMPLE_WIDTH > ALIGNED_W) ? (SAMPLE_WIDTH - ALIGNED_W) : 0;
  localparam int WIDE_W     = SAMPLE_WIDTH + ALIGNED_W;

  logic signed [SAMPLE_WIDTH:0]   ext;
  logic signed [SAMPLE_WIDTH:0]   ext_abs;
  logic        [WIDE_W-1:0]       mag_wide;
  logic        [ALIGNED_W-1:0]    mag;
  logic        [2*ALIGNED_W-1:0]  prod;

  assign ext      = {sample[SAMPLE_WIDTH-1], sample};
  assign ext_abs  = ext[SAMPLE_WIDTH] ? -ext : ext;
  assign mag_wide = (WIDE_W'(ext_abs[SAMPLE_WIDTH-1:0]) << ALIGN_UP) >> ALIGN_DOWN;
  assign mag      = mag_wide[ALIGNED_W-1:0];
  assign prod     = mag * mag;

  always_ff @(posedge clk) begin
    if (en) begin
      square <= prod[SQ_W-1:0];
    end
  end

endmodule

### rtl/altd_isqrt.sv
module altd_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [altd_pkg::SUM_W-1:0]   radicand,
  output altd_pkg::isqrt_status_t      status,
  output logic [altd_pkg::LEVEL_W-1:0] root
);
  import altd_pkg::*;

  localparam int REM_W = LEVEL_W + 3;
  localparam int CNT_W = $clog2(LEVEL_W);

  logic [SUM_W-1:0]   rad_shift;
  logic [REM_W-1:0]   rem;
  logic [LEVEL_W-1:0] root_q;
  logic [CNT_W-1:0]   count;
  logic               busy;
  logic               done;

  logic [REM_W-1:0]   rem_shift;
  logic [REM_W-1:0]   trial;
  logic               ge;

  assign rem_shift = {rem[REM_W-3:0], rad_shift[SUM_W-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign ge        = (rem_shift >= trial);

  always_ff @(posedge clk) begin
    if (start) begin
      rad_shift <= radicand;
      rem       <= '0;
      root_q    <= '0;
      count     <= '0;
    end else if (busy) begin
      rad_shift <= rad_shift << 2;
      rem       <= ge ? (rem_shift - trial) : rem_shift;
      root_q    <= {root_q[LEVEL_W-2:0], ge};
      count     <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == CNT_W'(LEVEL_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign root        = root_q;

endmodule

### rtl/altd_smooth.sv
module altd_smooth (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         commit,
  input  logic [altd_pkg::LEVEL_W-1:0] level,
  input  logic [altd_pkg::ALPHA_W-1:0] alpha,
  input  logic [altd_pkg::LEVEL_W-1:0] threshold,
  output altd_pkg::smooth_result_t     result
);
  import altd_pkg::*;

  localparam int PROD_W = LEVEL_W + ALPHA_W;
  localparam logic [PROD_W:0] ROUND_HALF = {{PROD_W{1'b0}}, 1'b1} << (ALPHA_W - 1);

  logic [LEVEL_W-1:0] level_average;
  logic               above_state;
  logic               neg_q;
  logic [PROD_W-1:0]  prod_q;

  logic               neg;
  logic [LEVEL_W-1:0] mag;
  logic [PROD_W:0]    rounded;
  logic [LEVEL_W-1:0] stepv;
  logic [LEVEL_W:0]   up_sum;
  logic [LEVEL_W-1:0] avg;
  logic               above;
  change_t            change;

  assign neg = (level < level_average);
  assign mag = neg ? (level_average - level) : (level - level_average);

  always_ff @(posedge clk) begin
    if (start) begin
      neg_q  <= neg;
      prod_q <= PROD_W'(mag) * PROD_W'(alpha);
    end
  end

  assign rounded = {1'b0, prod_q} + ROUND_HALF;
  assign stepv   = rounded[ALPHA_W +: LEVEL_W];
  assign up_sum  = {1'b0, level_average} + {1'b0, stepv};

  always_comb begin
    if (neg_q) begin
      avg = (stepv > level_average) ? '0 : (level_average - stepv);
    end else begin
      avg = up_sum[LEVEL_W] ? '1 : up_sum[LEVEL_W-1:0];
    end
    above  = above_state;
    change = CHANGE_NONE;
    if (avg > threshold) begin
      above = 1'b1;
      if (!above_state) begin
        change = CHANGE_ABOVE;
      end
    end else if (avg < threshold) begin
      above = 1'b0;
      if (above_state) begin
        change = CHANGE_BELOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_average <= '0;
      above_state   <= 1'b0;
    end else if (commit) begin
      level_average <= avg;
      above_state   <= above;
    end
  end

  assign result.level_avg = avg;
  assign result.above     = above;
  assign result.change    = change;

endmodule

### rtl/audio_level_threshold_detector.sv
// Sample pair: accepted in IDLE, squared in two lanes, summed the next; no new pair until it is summed.
// Frame-end pair: summed, then the bit-serial square root in ROOT, then smoothing and threshold
// in UPDATE; the result is registered once the output is not stalled.
// A new pair is accepted while a finished result waits at the output.
// Synchronous reset: sum, pair count, average and flag clear, threshold = 1.0, alpha = 4588.
module audio_level_threshold_detector #(
  parameter int MAX_FRAME_PAIRS = altd_pkg::MAX_FRAME_PAIRS_DEFAULT,
  parameter int SAMPLE_WIDTH    = altd_pkg::SAMPLE_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]  left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]  right_sample,
  input  logic                            frame_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [altd_pkg::LEVEL_W-1:0]    frame_level,
  output logic [altd_pkg::LEVEL_W-1:0]    smoothed_level,
  output logic                            above_flag,
  output logic [1:0]                      flag_change,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [altd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [altd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import altd_pkg::*;

  localparam int PC_W = $clog2(MAX_FRAME_PAIRS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ACCUM  = 4'b0010,
    ST_ROOT   = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [LEVEL_W-1:0] level_threshold;
  logic [ALPHA_W-1:0] smoothing_alpha;
  logic [SUM_W-1:0]   sum_of_squares;
  logic [PC_W-1:0]    pair_count;
  logic               frame_flag;

  logic               in_accept;
  logic [SQ_W-1:0]    left_square;
  logic [SQ_W-1:0]    right_square;
  logic [SUM_W+1:0]   sum_total;
  logic [SUM_W-1:0]   sum_sat;
  logic               root_start;
  isqrt_status_t      root_status;
  logic [LEVEL_W-1:0] root;
  logic               out_free;
  logic               commit;
  smooth_result_t     smooth_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign commit    = (state == ST_UPDATE) && out_free;

  altd_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_left (
    .clk    (clk),
    .en     (in_accept),
    .sample (left_sample),
    .square (left_square)
  );

  altd_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_right (
    .clk    (clk),
    .en     (in_accept),
    .sample (right_sample),
    .square (right_square)
  );

  assign sum_total  = {2'b00, sum_of_squares} + (SUM_W+2)'(left_square)
                    + (SUM_W+2)'(right_square);
  assign sum_sat    = (sum_total[SUM_W+1:SUM_W] != 2'b00) ? '1 : sum_total[SUM_W-1:0];
  assign root_start = (state == ST_ACCUM) && frame_flag;

  altd_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sum_sat),
    .status   (root_status),
    .root     (root)
  );

  altd_smooth u_smooth (
    .clk       (clk),
    .rst       (rst),
    .start     ((state == ST_ROOT) && root_status.done),
    .commit    (commit),
    .level     (root),
    .alpha     (smoothing_alpha),
    .threshold (level_threshold),
    .result    (smooth_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        state_next = frame_flag ? ST_ROOT : ST_IDLE;
      end
      ST_ROOT: begin
        if (root_status.done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      level_threshold <= THRESHOLD_RESET;
      smoothing_alpha <= ALPHA_RESET;
      sum_of_squares  <= '0;
      pair_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD: level_threshold <= cfg_data[LEVEL_W-1:0];
          REG_ALPHA:     smoothing_alpha <= cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_ACCUM) begin
        if (frame_flag) begin
          sum_of_squares <= '0;
          pair_count     <= '0;
        end else begin
          sum_of_squares <= sum_sat;
          if (pair_count != PC_W'(MAX_FRAME_PAIRS)) begin
            pair_count <= pair_count + 1'b1;
          end
        end
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      frame_flag <= frame_end;
    end
    if (commit) begin
      frame_level    <= root;
      smoothed_level <= smooth_res.level_avg;
      above_flag     <= smooth_res.above;
      flag_change    <= smooth_res.change;
    end
  end

endmodule

### rtl/altd_checker.sv
module altd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [altd_pkg::LEVEL_W-1:0]    frame_level,
  input logic [altd_pkg::LEVEL_W-1:0]    smoothed_level,
  input logic                            above_flag,
  input logic [1:0]                      flag_change
);
  import altd_pkg::*;

  `include "audio_level_threshold_detector_assert.svh"

  `ALTD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(frame_level) && $stable(smoothed_level))
  `ALTD_ASSERT_IMP(a_change_above, clk, rst, out_valid && (flag_change == CHANGE_ABOVE), above_flag)
  `ALTD_ASSERT_IMP(a_change_below, clk, rst, out_valid && (flag_change == CHANGE_BELOW), !above_flag)
  `ALTD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ALTD_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind audio_level_threshold_detector altd_checker u_altd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .frame_level    (frame_level),
  .smoothed_level (smoothed_level),
  .above_flag     (above_flag),
  .flag_change    (flag_change)
);
